### sv/lbp_texture_histogram_top_defines.svh
// Assertion macros shared by the checker of the LBP histogram block.
// No dependencies.
`ifndef LBP_TEXTURE_HISTOGRAM_TOP_DEFINES_SVH
`define LBP_TEXTURE_HISTOGRAM_TOP_DEFINES_SVH
// implication checked every clock edge outside reset
`define LBP_ASSERT_IMP(label, clk_sig, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LBP_ASSERT_NEXT(label, clk_sig, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### sv/lbp_pkg.sv
// Shared types and constants for the LBP texture histogram block.
// No dependencies.
package lbp_pkg;
	localparam int MaxWidth = 2048;
	localparam int MaxHeight = 2048;
	localparam int FracBits = 16;
	localparam int ColW = $clog2(MaxWidth);
	localparam int RowW = $clog2(MaxHeight) + 1;
	localparam int CntW = 22;
	localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_READ = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// Entry in the queue between front and back.
	typedef struct packed {
		op_t op;
		logic counted;
		logic [7:0] code;
		logic [7:0] bin;
	} cmd_t;
endpackage

### sv/lbp_front.sv
// Front end: line stores, 3x3 window and LBP code formation.
// Depends on lbp_pkg.
module lbp_front import lbp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic take,
	input op_t op,
	input logic [7:0] pixel,
	input logic [7:0] bin_index,
	input logic [11:0] image_width,
	input logic [11:0] image_height,
	output logic cmd_valid,
	output cmd_t cmd
);
	logic [7:0] upper_mem [MaxWidth];
	logic [7:0] middle_mem [MaxWidth];
	logic [7:0] win_q [6];
	logic [ColW:0] col_q;
	logic [RowW-1:0] row_q;
	logic [12:0] w_eff, h_eff;
	logic [ColW-1:0] c_idx;
	logic [7:0] up, mid, ctr;
	logic in_frame, interior;
	logic [7:0] code;

	// Stage 1: line store read; pixel and flags held.
	logic s1_q;
	op_t op_s1;
	logic [7:0] pix_s1, bin_s1, up_s1, mid_s1;
	logic int_s1;
	logic fr_s1;
	logic [ColW-1:0] c_s1;
	logic shift_s1;

	always_comb begin
		w_eff = (image_width < 12'd3) ? 13'd3 :
			(13'(image_width) > 13'(MaxWidth)) ? 13'(MaxWidth) : 13'(image_width);
		h_eff = (image_height < 12'd3) ? 13'd3 :
			(13'(image_height) > 13'(MaxHeight)) ? 13'(MaxHeight) : 13'(image_height);
		c_idx = (col_q >= (ColW+1)'(MaxWidth)) ? ColW'(MaxWidth - 1) : col_q[ColW-1:0];
		in_frame = 13'(row_q) < h_eff;
		interior = (row_q >= RowW'(2)) && (col_q >= (ColW+1)'(2));
	end

	assign shift_s1 = s1_q && (op_s1 == OP_PUSH) && fr_s1;

	// read-before-write line stores, registered read
	always_ff @(posedge clk) begin
		if (take && op == OP_PUSH && in_frame) begin
			up_s1 <= upper_mem[c_idx];
			mid_s1 <= middle_mem[c_idx];
			middle_mem[c_idx] <= pixel;
		end
		// move the old middle entry up once it has been read out
		if (shift_s1) upper_mem[c_s1] <= mid_s1;
		c_s1 <= c_idx;
		pix_s1 <= pixel;
		bin_s1 <= bin_index;
		op_s1 <= op;
		int_s1 <= interior && in_frame;
		fr_s1 <= in_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			s1_q <= 1'b0;
		end else begin
			s1_q <= take;
			if (take && op == OP_CLEAR) begin
				col_q <= '0;
				row_q <= '0;
			end else if (take && op == OP_PUSH && in_frame) begin
				if (13'(col_q) + 13'd1 >= w_eff) begin
					col_q <= '0;
					row_q <= row_q + RowW'(1);
				end else begin
					col_q <= col_q + (ColW+1)'(1);
				end
			end
		end
	end

	assign up = up_s1;
	assign mid = mid_s1;
	assign ctr = win_q[4];

	always_comb begin
		code[0] = win_q[0] >= ctr;
		code[1] = win_q[3] >= ctr;
		code[2] = up >= ctr;
		code[3] = mid >= ctr;
		code[4] = pix_s1 >= ctr;
		code[5] = win_q[5] >= ctr;
		code[6] = win_q[2] >= ctr;
		code[7] = win_q[1] >= ctr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= 8'd0;
		end else if (take && op == OP_CLEAR) begin
			for (int i = 0; i < 6; i++) win_q[i] <= 8'd0;
		end else if (shift_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up;
			win_q[4] <= mid;
			win_q[5] <= pix_s1;
		end
	end

	assign cmd_valid = s1_q;
	assign cmd.op = op_s1;
	assign cmd.counted = (op_s1 == OP_PUSH) && int_s1;
	assign cmd.code = code;
	assign cmd.bin = bin_s1;
endmodule

### sv/lbp_queue.sv
// Two-entry command queue between front and back.
// Depends on lbp_pkg.
module lbp_queue import lbp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input cmd_t wdata,
	input logic rd,
	output logic not_empty,
	output logic not_full,
	output cmd_t rdata
);
	cmd_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;

	assign not_empty = cnt_q != 2'd0;
	assign not_full = cnt_q != 2'd2;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

### sv/lbp_back.sv
// Back end: histogram memory update, bin read and serial fraction divider.
// Depends on lbp_pkg.
module lbp_back import lbp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_take,
	output logic done,
	output logic code_valid,
	output logic [7:0] lbp_code,
	output logic [CntW-1:0] bin_count,
	output logic [16:0] bin_fraction,
	output logic [CntW-1:0] total_codes
);
	localparam int QW = CntW + FracBits;
	localparam int StepW = $clog2(QW + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CLEAR = 5'b00010,
		ST_RMW = 5'b00100,
		ST_READ = 5'b01000,
		ST_DIV = 5'b10000
	} st_t;

	st_t st_q;
	logic [CntW-1:0] hist_mem [256];
	logic [255:0] vld_q;
	logic [CntW-1:0] rd_q, total_q;
	cmd_t cur_q;
	logic [QW-1:0] num_q;
	logic [CntW:0] rem_q;
	logic [StepW-1:0] step_q;
	logic [CntW-1:0] cnt_eff;
	logic [CntW:0] rem_sh;
	logic [7:0] cur_idx;

	assign cmd_take = (st_q == ST_IDLE) && cmd_valid;
	assign cur_idx = (cur_q.op == OP_READ) ? cur_q.bin : cur_q.code;
	assign cnt_eff = vld_q[cur_idx] ? rd_q : '0;
	assign rem_sh = {rem_q[CntW-1:0], num_q[QW-1]};
	assign total_codes = total_q;

	always_ff @(posedge clk) begin
		if (cmd_take) rd_q <= hist_mem[cmd.op == OP_PUSH ? cmd.code : cmd.bin];
		if (st_q == ST_RMW)
			hist_mem[cur_q.code] <= (cnt_eff == CountMax) ? cnt_eff : cnt_eff + CntW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			vld_q <= '0;
			total_q <= '0;
			done <= 1'b0;
			code_valid <= 1'b0;
			lbp_code <= '0;
			bin_count <= '0;
			bin_fraction <= '0;
			cur_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cur_q <= cmd;
						if (cmd.op == OP_PUSH && !cmd.counted) begin
							done <= 1'b1;
							code_valid <= 1'b0;
							lbp_code <= '0;
							bin_count <= '0;
							bin_fraction <= '0;
						end else begin
							case (cmd.op)
								OP_PUSH: st_q <= ST_RMW;
								OP_READ: st_q <= ST_READ;
								OP_CLEAR: st_q <= ST_CLEAR;
								default: begin
									done <= 1'b1;
									code_valid <= 1'b0;
									lbp_code <= '0;
									bin_count <= '0;
									bin_fraction <= '0;
								end
							endcase
						end
					end
				end
				ST_CLEAR: begin
					vld_q <= '0;
					total_q <= '0;
					done <= 1'b1;
					code_valid <= 1'b0;
					lbp_code <= '0;
					bin_count <= '0;
					bin_fraction <= '0;
					st_q <= ST_IDLE;
				end
				ST_RMW: begin
					vld_q[cur_q.code] <= 1'b1;
					if (total_q != CountMax) total_q <= total_q + CntW'(1);
					done <= 1'b1;
					code_valid <= 1'b1;
					lbp_code <= cur_q.code;
					bin_count <= '0;
					bin_fraction <= '0;
					st_q <= ST_IDLE;
				end
				ST_READ: begin
					bin_count <= cnt_eff;
					num_q <= {cnt_eff, FracBits'(0)};
					rem_q <= '0;
					step_q <= StepW'(QW);
					if (total_q == '0) begin
						done <= 1'b1;
						code_valid <= 1'b0;
						lbp_code <= '0;
						bin_fraction <= '0;
						st_q <= ST_IDLE;
					end else begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					if (step_q == '0) begin
						done <= 1'b1;
						code_valid <= 1'b0;
						lbp_code <= '0;
						bin_fraction <= num_q[16:0];
						st_q <= ST_IDLE;
					end else begin
						step_q <= step_q - StepW'(1);
						if (rem_sh >= {1'b0, total_q}) begin
							rem_q <= rem_sh - {1'b0, total_q};
							num_q <= {num_q[QW-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							num_q <= {num_q[QW-2:0], 1'b0};
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### sv/lbp_texture_histogram_top.sv
// Top level of the LBP texture histogram block.
// Depends on lbp_pkg, lbp_front, lbp_queue, lbp_back.
//
// Usage: drive opcode/pixel/bin_index with start high while busy is low;
// the command is taken at that edge. Each command gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall.
// Configuration: cfg_valid/cfg_ready write cfg_index (0 width, 1 height)
// with cfg_data; write only while idle.
// Path to done: front stage register, queue, back end; a push outside
// the interior or beyond the frame ends from idle, a counted push via
// the update state, a clear via the clear state, a read via the read
// state and, with a nonempty histogram, the serial divider.
// One command in flight at a time: busy stays high through the done
// cycle, so a new command is taken in the next cycle at the earliest.
// Reset clears the histogram valid bits, total, positions and window at
// once; line stores hold undefined data until written.
module lbp_texture_histogram_top import lbp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] opcode,
	input logic [7:0] pixel,
	input logic [7:0] bin_index,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [11:0] cfg_data,
	output logic done,
	output logic code_valid,
	output logic [7:0] lbp_code,
	output logic [21:0] bin_count,
	output logic [16:0] bin_fraction,
	output logic [21:0] total_codes
);
	logic [11:0] width_q, height_q;
	logic take, pend_q;
	logic f_valid, q_ne, q_nf, b_take;
	cmd_t f_cmd, q_cmd;
	logic b_done;

	assign cfg_ready = 1'b1;
	assign busy = pend_q;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd2048;
			height_q <= 12'd2048;
			pend_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_index == REG_WIDTH) width_q <= cfg_data;
			if (cfg_valid && cfg_index == REG_HEIGHT) height_q <= cfg_data;
			if (take) pend_q <= 1'b1;
			else if (done) pend_q <= 1'b0;
		end
	end

	lbp_front u_front (
		.clk, .arst_n, .take,
		.op(op_t'(opcode)), .pixel, .bin_index,
		.image_width(width_q), .image_height(height_q),
		.cmd_valid(f_valid), .cmd(f_cmd)
	);

	lbp_queue u_queue (
		.clk, .arst_n,
		.wr(f_valid && q_nf), .wdata(f_cmd),
		.rd(b_take), .not_empty(q_ne), .not_full(q_nf), .rdata(q_cmd)
	);

	lbp_back u_back (
		.clk, .arst_n,
		.cmd_valid(q_ne), .cmd(q_cmd), .cmd_take(b_take),
		.done(b_done),
		.code_valid, .lbp_code, .bin_count, .bin_fraction, .total_codes
	);

	assign done = b_done;
endmodule

### sv/lbp_texture_histogram_checker.sv
// Port-level checker for the LBP histogram block, bound to the top level.
// Depends on lbp_texture_histogram_top_defines.svh.
`include "lbp_texture_histogram_top_defines.svh"
module lbp_texture_histogram_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic code_valid,
	input logic [21:0] bin_count,
	input logic [16:0] bin_fraction,
	input logic [21:0] total_codes
);
	`LBP_ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy, "busy missing after take")
	`LBP_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy, "result without command")
	`LBP_ASSERT_IMP(a_code_nocount, clk, arst_n, done && code_valid, bin_count == 22'd0,
		"count on push")
	`LBP_ASSERT_IMP(a_frac_zero, clk, arst_n, done && total_codes == 22'd0,
		bin_fraction == 17'd0, "fraction with empty histogram")
endmodule

bind lbp_texture_histogram_top lbp_texture_histogram_checker u_checker (
	.clk, .arst_n, .start, .busy, .done, .code_valid,
	.bin_count, .bin_fraction, .total_codes
);
